[hw/rtl/cdq_pkg.sv]
`default_nettype none

package cdq_pkg;

  // Request codes carried on the op field.
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_REAR  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_REAR   = 3'd3;
  localparam logic [2:0] OP_PEEK_FRONT = 3'd4;
  localparam logic [2:0] OP_PEEK_REAR  = 3'd5;

  // Status codes returned with each result word.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } cdq_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
  } cdq_cmd_t;

endpackage

`default_nettype wire

[hw/rtl/cdq_ifs.sv]
`default_nettype none

// Request channel: one operation and its push value per word.
interface cdq_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic signed [31:0] value_in;

  modport source (output valid, output op, output value_in, input ready);
  modport sink   (input valid, input op, input value_in, output ready);
endinterface

// Response channel: data word, status and the flags after the request.
interface cdq_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value_out;
  logic [1:0]         status;
  logic               now_empty;
  logic               now_full;

  modport source (output valid, output value_out, output status,
                  output now_empty, output now_full, input ready);
  modport sink   (input valid, input value_out, input status,
                  input now_empty, input now_full, output ready);
endinterface

`default_nettype wire

[hw/rtl/cdq_ram.sv]
`default_nettype none

module cdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/cdq_ctrl.sv]
`default_nettype none

module cdq_ctrl
  import cdq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output cdq_cmd_t  cmd
);

  cdq_state_t state;
  cdq_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: take a word, run it against the ring, then hold the result.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        if (rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    req_ready = 1'b0;
    rsp_valid = 1'b0;
    cmd       = '0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
      end
      S_RESP: begin
        rsp_valid = 1'b1;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/cdq_datapath.sv]
`default_nettype none

module cdq_datapath
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cdq_cmd_t           cmd,
  input  wire logic [2:0]         op_in,
  input  wire logic signed [31:0] value_in,
  output logic signed [31:0]      value_out,
  output logic [1:0]              status,
  output logic                    now_empty,
  output logic                    now_full
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  typedef logic [PTR_W-1:0] ptr_t;
  localparam ptr_t LAST = ptr_t'(DEPTH - 1);

  ptr_t               head;
  ptr_t               head_next;
  ptr_t               tail;
  ptr_t               tail_next;
  logic [2:0]         op;
  logic signed [31:0] value;
  logic [1:0]         status_next;
  logic               hit;
  logic               hit_next;
  logic               ram_we;
  ptr_t               ram_waddr;
  logic               ram_re;
  ptr_t               ram_raddr;
  logic [DATA_W-1:0]  ram_rdata;
  logic               ring_empty;
  logic               ring_full;

  function automatic ptr_t wrap_next(ptr_t p);
    return (p == LAST) ? '0 : p + ptr_t'(1);
  endfunction

  function automatic ptr_t wrap_prev(ptr_t p);
    return (p == '0) ? LAST : p - ptr_t'(1);
  endfunction

  assign ring_empty = (head == tail);
  assign ring_full  = (head == wrap_next(tail));

  // Decode the held request against the pointers.
  always_comb begin
    head_next   = head;
    tail_next   = tail;
    status_next = ST_OK;
    hit_next    = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = head;
    ram_re      = 1'b0;
    ram_raddr   = tail;
    case (op)
      OP_PUSH_FRONT: begin
        if (ring_full) begin
          status_next = ST_FULL;
        end else begin
          ram_we    = cmd.exec;
          ram_waddr = head;
          head_next = wrap_prev(head);
        end
      end
      OP_PUSH_REAR: begin
        if (ring_full) begin
          status_next = ST_FULL;
        end else begin
          ram_we    = cmd.exec;
          ram_waddr = wrap_next(tail);
          tail_next = wrap_next(tail);
        end
      end
      OP_POP_FRONT, OP_PEEK_FRONT: begin
        if (ring_empty) begin
          status_next = ST_EMPTY;
        end else begin
          hit_next  = 1'b1;
          ram_re    = cmd.exec;
          ram_raddr = wrap_next(head);
          if (op == OP_POP_FRONT) begin
            head_next = wrap_next(head);
          end
        end
      end
      OP_POP_REAR, OP_PEEK_REAR: begin
        if (ring_empty) begin
          status_next = ST_EMPTY;
        end else begin
          hit_next  = 1'b1;
          ram_re    = cmd.exec;
          ram_raddr = tail;
          if (op == OP_POP_REAR) begin
            tail_next = wrap_prev(tail);
          end
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  // Pointer registers change only while a request executes.
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else if (cmd.exec) begin
      head <= head_next;
      tail <= tail_next;
    end
  end

  // Capture the request word and the outcome of its execution.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= op_in;
      value <= value_in;
    end
    if (cmd.exec) begin
      status <= status_next;
      hit    <= hit_next;
    end
  end

  cdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Read data holds until the next read, so it stays put during a stall.
  assign value_out = hit ? signed'(ram_rdata) : '0;
  assign now_empty = ring_empty;
  assign now_full  = ring_full;

endmodule

`default_nettype wire

[hw/rtl/circular_deque_unit.sv]
// Double-ended queue in a ring of DEPTH slots, holding up to DEPTH-1 words.
// Requests arrive on the req channel (op, value_in) and every request gives
// exactly one word on the rsp channel: value_out, status (ok, full, empty)
// and the empty and full flags as they stand after the request.
// Both channels use a valid/ready handshake; a word moves when both are high.
// Each request passes the accept, execute and response steps of the
// controller, with the execute step waiting on the registered read port of
// the slot memory; the response word is valid in the response step.
// One request is in flight at a time, so no new request is taken until the
// last response word has been delivered.
// When the receiver stalls, the response word holds steady and no new
// request is taken until it has been delivered.
// Reset (rst, synchronous) empties the deque by clearing both pointers; the
// slot memory is not cleared, and only slots holding live words are read.
`default_nettype none

module circular_deque_unit
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input wire logic clk,
  input wire logic rst,
  cdq_req_if.sink  req,
  cdq_rsp_if.source rsp
);

  cdq_cmd_t cmd;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  cdq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .op_in     (req.op),
    .value_in  (req.value_in),
    .value_out (rsp.value_out),
    .status    (rsp.status),
    .now_empty (rsp.now_empty),
    .now_full  (rsp.now_full)
  );

endmodule

`default_nettype wire

[hw/rtl/cdq_checker.sv]
`default_nettype none

module cdq_checker
  import cdq_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [31:0] value_out,
  input wire logic [1:0]  status,
  input wire logic        now_empty,
  input wire logic        now_full
);

  // No request is taken while a response is still waiting.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready)
    else $error("request accepted while a response is pending");

  // Every accepted request is answered after the execute state.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |-> ##2 rsp_valid)
    else $error("response missing two cycles after a request");

  // A stalled response word holds its data.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(value_out) && $stable(status)))
    else $error("stalled response changed");

  // A rejected request never returns data.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (status == ST_FULL || status == ST_EMPTY)) |-> (value_out == '0))
    else $error("rejected request returned data");

  // The ring is never empty and full at once.
  a_flags: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(now_empty && now_full))
    else $error("empty and full flags both set");

endmodule

bind circular_deque_unit cdq_checker u_cdq_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .value_out (rsp.value_out),
  .status    (rsp.status),
  .now_empty (rsp.now_empty),
  .now_full  (rsp.now_full)
);

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import cdq_pkg::*;

  localparam int unsigned DEPTH = 8;

  // Op codes that the block leaves undecoded; they act as no-ops.
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  localparam logic signed [31:0] WORD_MIN  = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] WORD_ONES = -32'sd1;

  typedef logic [$clog2(DEPTH)-1:0] shadow_ptr_t;

  // One response word as the deque should produce it.
  typedef struct {
    logic signed [31:0] word;
    logic [1:0]         status;
    logic               empty_flag;
    logic               full_flag;
  } deque_result_t;

  logic clk;
  logic rst;

  cdq_req_if req_ch ();
  cdq_rsp_if rsp_ch ();

  circular_deque_unit #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Shadow copy of the deque: pointers and slot contents.
  shadow_ptr_t        shadow_head;
  shadow_ptr_t        shadow_tail;
  logic signed [31:0] shadow_slots [DEPTH];

  deque_result_t expected_results [$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned error_count;
  int unsigned words_checked;
  int unsigned push_count;
  int unsigned pop_count;
  int unsigned peek_count;
  int unsigned spare_count;
  int unsigned full_rejects;
  int unsigned empty_rejects;
  int unsigned full_reached;
  int unsigned empty_reached;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Fixed limit on the whole run.
  initial begin
    #2_000_000;
    $display("timeout at %0t with %0d responses outstanding", $time,
             expected_results.size());
    $display("simulation failed");
    $finish;
  end

  function automatic shadow_ptr_t ring_next(input shadow_ptr_t p);
    return shadow_ptr_t'((p + 1) % DEPTH);
  endfunction

  function automatic shadow_ptr_t ring_prev(input shadow_ptr_t p);
    return shadow_ptr_t'((p + DEPTH - 1) % DEPTH);
  endfunction

  function automatic logic shadow_empty();
    return shadow_head == shadow_tail;
  endfunction

  function automatic logic shadow_full();
    return shadow_head == ring_next(shadow_tail);
  endfunction

  // Apply one request to the shadow deque and return the response it gives.
  function automatic deque_result_t predict_deque(input logic [2:0] op,
                                                  input logic signed [31:0] value);
    deque_result_t res;
    res.word       = '0;
    res.status     = ST_OK;
    res.empty_flag = 1'b0;
    res.full_flag  = 1'b0;
    case (op)
      OP_PUSH_FRONT: begin
        if (shadow_full()) begin
          res.status = ST_FULL;
        end else begin
          shadow_slots[shadow_head] = value;
          shadow_head = ring_prev(shadow_head);
        end
      end
      OP_PUSH_REAR: begin
        if (shadow_full()) begin
          res.status = ST_FULL;
        end else begin
          shadow_tail = ring_next(shadow_tail);
          shadow_slots[shadow_tail] = value;
        end
      end
      OP_POP_FRONT: begin
        if (shadow_empty()) begin
          res.status = ST_EMPTY;
        end else begin
          shadow_head = ring_next(shadow_head);
          res.word = shadow_slots[shadow_head];
        end
      end
      OP_POP_REAR: begin
        if (shadow_empty()) begin
          res.status = ST_EMPTY;
        end else begin
          res.word = shadow_slots[shadow_tail];
          shadow_tail = ring_prev(shadow_tail);
        end
      end
      OP_PEEK_FRONT: begin
        if (shadow_empty()) begin
          res.status = ST_EMPTY;
        end else begin
          res.word = shadow_slots[ring_next(shadow_head)];
        end
      end
      OP_PEEK_REAR: begin
        if (shadow_empty()) begin
          res.status = ST_EMPTY;
        end else begin
          res.word = shadow_slots[shadow_tail];
        end
      end
      default: begin
      end
    endcase
    res.empty_flag = shadow_empty();
    res.full_flag  = shadow_full();
    return res;
  endfunction

  // Present one request word, wait for it to be taken, then log its response.
  task automatic send_request(input logic [2:0] op, input logic signed [31:0] value);
    deque_result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.op       <= op;
    req_ch.value_in <= value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = predict_deque(op, value);
    expected_results.push_back(predicted);
    case (op)
      OP_PUSH_FRONT, OP_PUSH_REAR: push_count++;
      OP_POP_FRONT, OP_POP_REAR:   pop_count++;
      OP_PEEK_FRONT, OP_PEEK_REAR: peek_count++;
      default:                     spare_count++;
    endcase
    if (predicted.status == ST_FULL) full_rejects++;
    if (predicted.status == ST_EMPTY) empty_rejects++;
    if (predicted.full_flag) full_reached++;
    if (predicted.empty_flag) empty_reached++;
  endtask

  // Stop sending and wait until every outstanding response has come back.
  task automatic wait_responses_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // The receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Compare every delivered response word with the oldest prediction.
  always @(posedge clk) begin
    deque_result_t exp_res;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected response word: value_out %0d status %0d empty %0b full %0b",
                 $time, rsp_ch.value_out, rsp_ch.status, rsp_ch.now_empty,
                 rsp_ch.now_full);
        error_count++;
      end else begin
        exp_res = expected_results.pop_front();
        words_checked++;
        if (rsp_ch.value_out !== exp_res.word) begin
          $display("%0t: value_out mismatch: expected %0d actual %0d", $time,
                   exp_res.word, rsp_ch.value_out);
          error_count++;
        end
        if (rsp_ch.status !== exp_res.status) begin
          $display("%0t: status mismatch: expected %0d actual %0d", $time,
                   exp_res.status, rsp_ch.status);
          error_count++;
        end
        if (rsp_ch.now_empty !== exp_res.empty_flag) begin
          $display("%0t: now_empty mismatch: expected %0b actual %0b", $time,
                   exp_res.empty_flag, rsp_ch.now_empty);
          error_count++;
        end
        if (rsp_ch.now_full !== exp_res.full_flag) begin
          $display("%0t: now_full mismatch: expected %0b actual %0b", $time,
                   exp_res.full_flag, rsp_ch.now_full);
          error_count++;
        end
      end
    end
  end

  // Corner cases: both ends on an empty deque, extreme words, filling to
  // full, pushes against a full deque, and the spare op codes.
  task automatic test_directed_corners();
    send_request(OP_PEEK_FRONT, 32'sd0);
    send_request(OP_PEEK_REAR, 32'sd0);
    send_request(OP_POP_FRONT, 32'sd0);
    send_request(OP_POP_REAR, 32'sd0);
    send_request(OP_SPARE_6, WORD_ONES);
    send_request(OP_SPARE_7, WORD_MAX);
    send_request(OP_PUSH_REAR, WORD_MAX);
    send_request(OP_PUSH_FRONT, WORD_MIN);
    send_request(OP_PEEK_FRONT, WORD_ONES);
    send_request(OP_PEEK_REAR, WORD_ONES);
    send_request(OP_PUSH_REAR, 32'sd0);
    send_request(OP_PUSH_FRONT, WORD_ONES);
    send_request(OP_PUSH_REAR, 32'sh5555_5555);
    send_request(OP_PUSH_FRONT, 32'shAAAA_AAAA);
    send_request(OP_PUSH_REAR, 32'sd1);
    send_request(OP_PUSH_FRONT, 32'sd2);
    send_request(OP_PUSH_REAR, 32'sd3);
    send_request(OP_SPARE_6, 32'sd0);
    send_request(OP_PEEK_REAR, 32'sd0);
    send_request(OP_POP_REAR, 32'sd0);
    send_request(OP_POP_FRONT, 32'sd0);
    send_request(OP_POP_REAR, 32'sd0);
    send_request(OP_PEEK_FRONT, 32'sd0);
    wait_responses_drained();
  endtask

  // Fill and drain runs with random content, so the pointers wrap many
  // times and both full and empty are hit often; a few spare codes mix in.
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    logic        filling;
    logic [2:0]  op;
    logic signed [31:0] value;
    sent    = 0;
    filling = 1'b1;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        op = ($urandom_range(0, 1) != 0) ? OP_SPARE_7 : OP_SPARE_6;
      end else if (pick < 73) begin
        if (filling) begin
          op = ($urandom_range(0, 1) != 0) ? OP_PUSH_REAR : OP_PUSH_FRONT;
        end else begin
          op = ($urandom_range(0, 1) != 0) ? OP_POP_REAR : OP_POP_FRONT;
        end
      end else if (pick < 88) begin
        if (filling) begin
          op = ($urandom_range(0, 1) != 0) ? OP_POP_REAR : OP_POP_FRONT;
        end else begin
          op = ($urandom_range(0, 1) != 0) ? OP_PUSH_REAR : OP_PUSH_FRONT;
        end
      end else begin
        op = ($urandom_range(0, 1) != 0) ? OP_PEEK_REAR : OP_PEEK_FRONT;
      end
      case ($urandom_range(0, 19))
        0:       value = WORD_MIN;
        1:       value = WORD_MAX;
        2:       value = 32'sd0;
        3:       value = WORD_ONES;
        default: value = $urandom;
      endcase
      send_request(op, value);
      if (op != OP_SPARE_6 && op != OP_SPARE_7) sent++;
      // Turn around at the ends, or now and then in the middle.
      if (shadow_full()) filling = 1'b0;
      else if (shadow_empty()) filling = 1'b1;
      else if ($urandom_range(0, 99) < 4) filling = ~filling;
    end
  endtask

  // Some requests, then a full stop until the block has answered them all.
  task automatic test_pause_until_drained();
    int unsigned i;
    for (i = 0; i < 6; i++) begin
      send_request(OP_PUSH_REAR, $urandom);
    end
    wait_responses_drained();
    send_request(OP_PEEK_FRONT, 32'sd0);
    send_request(OP_POP_FRONT, 32'sd0);
  endtask

  initial begin
    shadow_head    = '0;
    shadow_tail    = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    error_count    = 0;
    words_checked  = 0;
    push_count     = 0;
    pop_count      = 0;
    peek_count     = 0;
    spare_count    = 0;
    full_rejects   = 0;
    empty_rejects  = 0;
    full_reached   = 0;
    empty_reached  = 0;
    foreach (shadow_slots[i]) shadow_slots[i] = '0;

    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.op       <= OP_PUSH_FRONT;
    req_ch.value_in <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_corners();

    // No idling on either side.
    test_random_traffic(220);
    test_pause_until_drained();

    // Sender idles often.
    send_idle_pct  = 61;
    recv_stall_pct = 0;
    test_random_traffic(220);
    wait_responses_drained();

    // Receiver stalls often.
    send_idle_pct  = 0;
    recv_stall_pct = 61;
    test_random_traffic(220);
    wait_responses_drained();

    // Both sides idle now and then.
    send_idle_pct  = 14;
    recv_stall_pct = 14;
    test_random_traffic(220);

    wait_responses_drained();
    repeat (10) @(posedge clk);

    $display("checked %0d responses: %0d pushes, %0d pops, %0d peeks, %0d spare codes",
             words_checked, push_count, pop_count, peek_count, spare_count);
    $display("rejected %0d pushes on full and %0d requests on empty;",
             full_rejects, empty_rejects);
    $display("full seen %0d times, empty %0d", full_reached, empty_reached);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
